>>> rtl/rectangle_outline_rasterizer_defines.svh
// ----------------------------------------------------------------------------
// Rectangle outline rasterizer: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_OUTLINE_RASTERIZER_DEFINES_SVH
`define RECTANGLE_OUTLINE_RASTERIZER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ROR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ROR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ror_pkg.sv
// ----------------------------------------------------------------------------
// Rectangle outline rasterizer package
// Operation codes, register map, default characters and shared types.
// ----------------------------------------------------------------------------
package ror_pkg;

    localparam int DEFAULT_CANVAS_WIDTH  = 64;
    localparam int DEFAULT_CANVAS_HEIGHT = 32;

    // Signed width for scan coordinates against rectangle bounds
    localparam int COORD_W = 10;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        OP_FILL = 2'd0,
        OP_DRAW = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } ror_op_t;

    localparam logic [2:0] REG_CANVAS       = 3'd0;
    localparam logic [2:0] REG_INTERIOR     = 3'd1;
    localparam logic [2:0] REG_HORIZONTAL   = 3'd2;
    localparam logic [2:0] REG_VERTICAL     = 3'd3;
    localparam logic [2:0] REG_INTERSECTION = 3'd4;
    localparam logic [2:0] REG_CORNER       = 3'd5;

    localparam logic [7:0] RST_CANVAS_CHAR       = 8'd46;
    localparam logic [7:0] RST_INTERIOR_CHAR     = 8'd35;
    localparam logic [7:0] RST_HORIZONTAL_CHAR   = 8'd45;
    localparam logic [7:0] RST_VERTICAL_CHAR     = 8'd124;
    localparam logic [7:0] RST_INTERSECTION_CHAR = 8'd42;
    localparam logic [7:0] RST_CORNER_CHAR       = 8'd43;

    typedef struct packed {
        logic [7:0] canvas_char;
        logic [7:0] interior_char;
        logic [7:0] horizontal_char;
        logic [7:0] vertical_char;
        logic [7:0] intersection_char;
        logic [7:0] corner_char;
    } ror_chars_t;

endpackage

>>> rtl/rectangle_outline_rasterizer.sv
// ----------------------------------------------------------------------------
// Rectangle outline rasterizer
// Character canvas with fill, rectangle outline draw and cell read commands.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result is
// shown on cell_char and done_op for exactly one cycle with done high, and
// the receiver cannot hold it off. A fill keeps the block busy while it
// sweeps every cell, a draw while it scans every cell and then drains its
// last write, a read inside the canvas through an address and a data state
// and a read outside it through the address state alone; operation three
// reports in the next cycle without raising busy. Fill and draw times are
// set by the canvas memory, which moves one cell per cycle: the draw reads
// one cell and writes the previous one back in the same cycle. The canvas
// holds no defined value after reset until a fill has run.
// ----------------------------------------------------------------------------
module rectangle_outline_rasterizer
#(
    parameter int CANVAS_WIDTH  = ror_pkg::DEFAULT_CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = ror_pkg::DEFAULT_CANVAS_HEIGHT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     operation,
    input  logic [5:0]                     pos_x,
    input  logic [4:0]                     pos_y,
    input  logic [5:0]                     rect_width,
    input  logic [4:0]                     rect_height,
    input  logic [7:0]                     fill_char,
    output logic                           done,
    output logic [7:0]                     cell_char,
    output logic [1:0]                     done_op,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ror_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ror_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ror_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ror_pkg::*;

    localparam int CELLS  = CANVAS_WIDTH * CANVAS_HEIGHT;
    localparam int ADDR_W = $clog2(CELLS);

    ror_chars_t        chars;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    ror_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .chars   (chars)
    );

    ror_canvas_ram
    #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    )
    u_canvas_ram
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ror_ctrl
    #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT),
        .ADDR_W        (ADDR_W)
    )
    u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .fill_char   (fill_char),
        .chars       (chars),
        .done        (done),
        .cell_char   (cell_char),
        .done_op     (done_op),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

endmodule

>>> rtl/ror_cfg_regs.sv
// ----------------------------------------------------------------------------
// Rectangle outline rasterizer configuration registers
// APB register bank holding the six drawing character codes.
// ----------------------------------------------------------------------------
module ror_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ror_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ror_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ror_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output ror_pkg::ror_chars_t            chars
);
    import ror_pkg::*;

    ror_chars_t chars_reg;
    logic [2:0] reg_index;
    logic       wr_xfer;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign wr_xfer   = psel && penable && pwrite && pready;
    assign chars     = chars_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_reg.canvas_char       <= RST_CANVAS_CHAR;
            chars_reg.interior_char     <= RST_INTERIOR_CHAR;
            chars_reg.horizontal_char   <= RST_HORIZONTAL_CHAR;
            chars_reg.vertical_char     <= RST_VERTICAL_CHAR;
            chars_reg.intersection_char <= RST_INTERSECTION_CHAR;
            chars_reg.corner_char       <= RST_CORNER_CHAR;
        end
        else if (wr_xfer)
        begin
            // Writes past the last register are dropped
            case (reg_index)
                REG_CANVAS:       chars_reg.canvas_char       <= pwdata[7:0];
                REG_INTERIOR:     chars_reg.interior_char     <= pwdata[7:0];
                REG_HORIZONTAL:   chars_reg.horizontal_char   <= pwdata[7:0];
                REG_VERTICAL:     chars_reg.vertical_char     <= pwdata[7:0];
                REG_INTERSECTION: chars_reg.intersection_char <= pwdata[7:0];
                REG_CORNER:       chars_reg.corner_char       <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_index)
            REG_CANVAS:       prdata[7:0] = chars_reg.canvas_char;
            REG_INTERIOR:     prdata[7:0] = chars_reg.interior_char;
            REG_HORIZONTAL:   prdata[7:0] = chars_reg.horizontal_char;
            REG_VERTICAL:     prdata[7:0] = chars_reg.vertical_char;
            REG_INTERSECTION: prdata[7:0] = chars_reg.intersection_char;
            REG_CORNER:       prdata[7:0] = chars_reg.corner_char;
            default:          prdata      = '0;
        endcase
    end

endmodule

>>> rtl/ror_canvas_ram.sv
// ----------------------------------------------------------------------------
// Rectangle outline rasterizer canvas memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ror_canvas_ram
#(
    parameter int DEPTH  = ror_pkg::DEFAULT_CANVAS_WIDTH * ror_pkg::DEFAULT_CANVAS_HEIGHT,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);
    logic [7:0] canvas_mem [DEPTH];
    logic [7:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            canvas_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= canvas_mem[raddr];
        end
    end

endmodule

>>> rtl/ror_ctrl.sv
// ----------------------------------------------------------------------------
// Rectangle outline rasterizer sequencer
// Runs fill sweeps, read-modify-write draw scans, single-cell reads and no-ops.
// ----------------------------------------------------------------------------
module ror_ctrl
#(
    parameter int CANVAS_WIDTH  = ror_pkg::DEFAULT_CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = ror_pkg::DEFAULT_CANVAS_HEIGHT,
    parameter int ADDR_W        = $clog2(CANVAS_WIDTH * CANVAS_HEIGHT)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          operation,
    input  logic [5:0]          pos_x,
    input  logic [4:0]          pos_y,
    input  logic [5:0]          rect_width,
    input  logic [4:0]          rect_height,
    input  logic [7:0]          fill_char,
    input  ror_pkg::ror_chars_t chars,
    output logic                done,
    output logic [7:0]          cell_char,
    output logic [1:0]          done_op,
    output logic                mem_we,
    output logic [ADDR_W-1:0]   mem_waddr,
    output logic [7:0]          mem_wdata,
    output logic                mem_re,
    output logic [ADDR_W-1:0]   mem_raddr,
    input  logic [7:0]          mem_rdata
);
    import ror_pkg::*;

    localparam int CELLS = CANVAS_WIDTH * CANVAS_HEIGHT;
    localparam int XW    = $clog2(CANVAS_WIDTH);
    localparam int YW    = $clog2(CANVAS_HEIGHT);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_DRAW,
        ST_FLUSH,
        ST_RD_ADDR,
        ST_RD_DATA
    } state_t;

    typedef struct packed {
        logic corner;
        logic hedge;
        logic vedge;
        logic interior;
    } mark_t;

    state_t                     state_reg;
    logic                       done_reg;
    logic [7:0]                 cell_char_reg;
    logic [1:0]                 done_op_reg;
    logic [ADDR_W-1:0]          addr_reg;
    logic [XW-1:0]              x_reg;
    logic [YW-1:0]              y_reg;
    logic                       s2_valid_reg;
    logic [ADDR_W-1:0]          s2_addr_reg;
    mark_t                      s2_mark_reg;

    logic signed [COORD_W-1:0]  lx_reg;
    logic signed [COORD_W-1:0]  rx_reg;
    logic signed [COORD_W-1:0]  by_reg;
    logic signed [COORD_W-1:0]  ty_reg;
    logic [7:0]                 fill_reg;
    logic                       rd_ok_reg;

    logic signed [COORD_W-1:0]  xs;
    logic signed [COORD_W-1:0]  ys;
    logic                       on_lr;
    logic                       on_tb;
    logic                       in_cols;
    logic                       in_rows;
    mark_t                      mark;
    logic                       last_cell;
    logic                       accept;

    function automatic logic [7:0] mark_cell(input logic [7:0] cur, input mark_t m,
                                             input ror_chars_t c);
        logic [7:0] v;
        v = cur;
        if (m.corner)
        begin
            v = c.corner_char;
        end
        if (m.hedge)
        begin
            v = (v == c.canvas_char || v == c.interior_char) ? c.horizontal_char
                                                             : c.intersection_char;
        end
        if (m.vedge)
        begin
            v = (v == c.canvas_char || v == c.interior_char) ? c.vertical_char
                                                             : c.intersection_char;
        end
        if (m.interior && v == c.canvas_char)
        begin
            v = c.interior_char;
        end
        return v;
    endfunction

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign cell_char = cell_char_reg;
    assign done_op   = done_op_reg;

    // Classify the cell being issued against the latched rectangle
    assign xs      = $signed(COORD_W'(x_reg));
    assign ys      = $signed(COORD_W'(y_reg));
    assign on_lr   = (xs == lx_reg) || (xs == rx_reg);
    assign on_tb   = (ys == ty_reg) || (ys == by_reg);
    assign in_cols = (xs > lx_reg) && (xs < rx_reg);
    assign in_rows = (ys > ty_reg) && (ys < by_reg);

    assign mark.corner   = on_lr && on_tb;
    assign mark.hedge    = in_cols && on_tb;
    assign mark.vedge    = in_rows && on_lr;
    assign mark.interior = in_cols && in_rows;

    assign last_cell = (addr_reg == ADDR_W'(CELLS - 1));

    // Read stage issues cell a+1 while write stage stores cell a, so the two
    // never touch the same entry within one scan.
    assign mem_re    = (state_reg == ST_DRAW) || (state_reg == ST_RD_ADDR && rd_ok_reg);
    assign mem_raddr = addr_reg;
    assign mem_we    = (state_reg == ST_FILL) || (s2_valid_reg && (|s2_mark_reg));
    assign mem_waddr = (state_reg == ST_FILL) ? addr_reg : s2_addr_reg;
    assign mem_wdata = (state_reg == ST_FILL) ? fill_reg
                                              : mark_cell(mem_rdata, s2_mark_reg, chars);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lx_reg    <= $signed(COORD_W'(pos_x));
            rx_reg    <= $signed(COORD_W'(pos_x) + COORD_W'(rect_width));
            by_reg    <= $signed(COORD_W'(pos_y));
            ty_reg    <= $signed(COORD_W'(pos_y) - COORD_W'(rect_height));
            fill_reg  <= fill_char;
            rd_ok_reg <= (COORD_W'(pos_x) < COORD_W'(CANVAS_WIDTH))
                      && (COORD_W'(pos_y) < COORD_W'(CANVAS_HEIGHT));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            cell_char_reg <= '0;
            done_op_reg   <= '0;
            addr_reg      <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            s2_valid_reg  <= 1'b0;
            s2_addr_reg   <= '0;
            s2_mark_reg   <= '0;
        end
        else
        begin
            done_reg     <= 1'b0;
            s2_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        x_reg    <= '0;
                        y_reg    <= '0;
                        addr_reg <= '0;
                        unique case (ror_op_t'(operation))
                            OP_FILL: state_reg <= ST_FILL;
                            OP_DRAW: state_reg <= ST_DRAW;
                            OP_READ:
                            begin
                                addr_reg  <= ADDR_W'(32'(pos_y) * CANVAS_WIDTH
                                                     + 32'(pos_x));
                                state_reg <= ST_RD_ADDR;
                            end
                            OP_NOP:
                            begin
                                done_reg      <= 1'b1;
                                done_op_reg   <= OP_NOP;
                                cell_char_reg <= '0;
                            end
                        endcase
                    end
                end
                ST_FILL:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (last_cell)
                    begin
                        state_reg     <= ST_IDLE;
                        done_reg      <= 1'b1;
                        done_op_reg   <= OP_FILL;
                        cell_char_reg <= '0;
                    end
                end
                ST_DRAW:
                begin
                    s2_valid_reg <= 1'b1;
                    s2_addr_reg  <= addr_reg;
                    s2_mark_reg  <= mark;
                    addr_reg     <= addr_reg + 1'b1;
                    if (x_reg == XW'(CANVAS_WIDTH - 1))
                    begin
                        x_reg <= '0;
                        y_reg <= y_reg + 1'b1;
                    end
                    else
                    begin
                        x_reg <= x_reg + 1'b1;
                    end
                    if (last_cell)
                    begin
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH:
                begin
                    // Last cell is written back this cycle
                    state_reg     <= ST_IDLE;
                    done_reg      <= 1'b1;
                    done_op_reg   <= OP_DRAW;
                    cell_char_reg <= '0;
                end
                ST_RD_ADDR:
                begin
                    if (rd_ok_reg)
                    begin
                        state_reg <= ST_RD_DATA;
                    end
                    else
                    begin
                        state_reg     <= ST_IDLE;
                        done_reg      <= 1'b1;
                        done_op_reg   <= OP_READ;
                        cell_char_reg <= '0;
                    end
                end
                ST_RD_DATA:
                begin
                    state_reg     <= ST_IDLE;
                    done_reg      <= 1'b1;
                    done_op_reg   <= OP_READ;
                    cell_char_reg <= mem_rdata;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/ror_checker.sv
// ----------------------------------------------------------------------------
// Rectangle outline rasterizer port checker
// Watches the command and result ports of the top level.
// ----------------------------------------------------------------------------
`include "rectangle_outline_rasterizer_defines.svh"

module ror_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] operation,
    input logic       done,
    input logic [7:0] cell_char,
    input logic [1:0] done_op
);
    import ror_pkg::*;

    // A result transfer only appears once the block is free again
    `ROR_ASSERT_SAME(a_done_not_busy, clk, rst_n, done, !busy, "result while busy")
    // Every busy period ends with its result
    `ROR_ASSERT_SAME(a_busy_ends_done, clk, rst_n, $fell(busy), done, "busy dropped, no result")
    // Fill, draw and read hold the block busy after the transfer
    `ROR_ASSERT_NEXT(a_work_busy, clk, rst_n, start && !busy && operation != OP_NOP, busy, "no busy after start")
    // Only a read returns a nonzero character
    `ROR_ASSERT_SAME(a_char_zero, clk, rst_n, done && done_op != OP_READ, cell_char == 8'd0, "nonzero char")

endmodule

bind rectangle_outline_rasterizer ror_checker u_ror_checker (.*);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Rectangle outline rasterizer testbench
// Drives fill, draw, read and no-op commands through the start/busy port and
// checks every acknowledge against a cycle-free model of the canvas. It opens
// with a directed table, then runs random phases under several character
// settings, each written and read back over APB while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ror_pkg::*;

    localparam int CANVAS_W = DEFAULT_CANVAS_WIDTH;
    localparam int CANVAS_H = DEFAULT_CANVAS_HEIGHT;
    localparam int CELLS    = CANVAS_W * CANVAS_H;

    // Register indexes past the map; writes there must be ignored.
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int PHASES     = 5;
    localparam int PHASE_CMDS = 53;

    typedef struct {
        ror_op_t    op;
        logic [5:0] x;
        logic [4:0] y;
        logic [5:0] w;
        logic [4:0] h;
        logic [7:0] fc;
        bit         typed;
        logic [7:0] exp_cell;
    } cmd_t;

    typedef struct {
        logic [7:0] char_code;
        ror_op_t    op;
    } ack_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            operation = OP_NOP;
    logic [5:0]            pos_x = '0;
    logic [4:0]            pos_y = '0;
    logic [5:0]            rect_width = '0;
    logic [4:0]            rect_height = '0;
    logic [7:0]            fill_char = '0;
    logic                  done;
    logic [7:0]            cell_char;
    logic [1:0]            done_op;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rectangle_outline_rasterizer dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #60_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Model state
    logic [7:0] canvas [CELLS];
    ror_chars_t chars;
    ack_t       pending_acks [$];
    int         errors = 0;
    int         n_fill = 0, n_draw = 0, n_read = 0, n_nop = 0, n_settings = 1;
    int         last_l = 0, last_r = 0, last_b = 0, last_t = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic [7:0] outline_mark(input logic [7:0] cur, input logic [7:0] mark);
        if (cur == chars.canvas_char || cur == chars.interior_char)
            return mark;
        return chars.intersection_char;
    endfunction

    // Apply one command to the canvas model and return the expected cell.
    task automatic rasterize(input cmd_t c, output logic [7:0] cell_val);
        int lx, rx, by, ty, x, y, i;
        bit in_cols, in_rows;
        cell_val = 8'h00;
        case (c.op)
            OP_FILL:
            begin
                for (i = 0; i < CELLS; i++)
                    canvas[i] = c.fc;
            end
            OP_DRAW:
            begin
                lx = int'(c.x);
                rx = lx + int'(c.w);
                by = int'(c.y);
                ty = by - int'(c.h);
                for (y = 0; y < CANVAS_H; y++)
                begin
                    for (x = 0; x < CANVAS_W; x++)
                    begin
                        i = y * CANVAS_W + x;
                        in_cols = (x > lx && x < rx);
                        in_rows = (y > ty && y < by);
                        if ((x == lx || x == rx) && (y == ty || y == by))
                            canvas[i] = chars.corner_char;
                        if (in_cols && (y == ty || y == by))
                            canvas[i] = outline_mark(canvas[i], chars.horizontal_char);
                        if (in_rows && (x == lx || x == rx))
                            canvas[i] = outline_mark(canvas[i], chars.vertical_char);
                        if (in_cols && in_rows && canvas[i] == chars.canvas_char)
                            canvas[i] = chars.interior_char;
                    end
                end
            end
            OP_READ:
            begin
                if (int'(c.x) < CANVAS_W && int'(c.y) < CANVAS_H)
                    cell_val = canvas[int'(c.y) * CANVAS_W + int'(c.x)];
            end
            default: ;
        endcase
    endtask

    function automatic logic [7:0] reg_value(input logic [2:0] idx);
        case (idx)
            REG_CANVAS:       return chars.canvas_char;
            REG_INTERIOR:     return chars.interior_char;
            REG_HORIZONTAL:   return chars.horizontal_char;
            REG_VERTICAL:     return chars.vertical_char;
            REG_INTERSECTION: return chars.intersection_char;
            REG_CORNER:       return chars.corner_char;
            default:          return 8'h00;
        endcase
    endfunction

    function automatic cmd_t mk(input ror_op_t op, input int x, input int y, input int w,
                                input int h, input int fc, input bit typed = 1'b0,
                                input int exp_cell = 0);
        cmd_t c;
        c.op = op;
        c.x = 6'(x);
        c.y = 5'(y);
        c.w = 6'(w);
        c.h = 5'(h);
        c.fc = 8'(fc);
        c.typed = typed;
        c.exp_cell = 8'(exp_cell);
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 40);
        return $urandom_range(100, 2500);
    endfunction

    // Present a command and hold it until the block takes it.
    task automatic send_cmd(input cmd_t c);
        logic [7:0] cell_val;
        ack_t a;
        operation   <= c.op;
        pos_x       <= c.x;
        pos_y       <= c.y;
        rect_width  <= c.w;
        rect_height <= c.h;
        fill_char   <= c.fc;
        start       <= 1'b1;
        do @(posedge clk); while (busy);
        rasterize(c, cell_val);
        a.char_code = c.typed ? c.exp_cell : cell_val;
        a.op = c.op;
        pending_acks.push_back(a);
        case (c.op)
            OP_FILL: n_fill++;
            OP_DRAW: n_draw++;
            OP_READ: n_read++;
            default: n_nop++;
        endcase
    endtask

    task automatic pause_after_cmd();
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_acks.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [7:0] val);
        logic [31:0] junk;
        junk = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[31:8], val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_regs();
        int i;
        logic [2:0] idx;
        for (i = int'(REG_CANVAS); i <= int'(REG_CORNER); i++)
        begin
            idx = 3'(i);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {idx, 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            if (prdata[7:0] !== reg_value(idx))
                report_mismatch($sformatf("register %0d reads %02h, expected %02h",
                                          i, prdata[7:0], reg_value(idx)));
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic apply_setting(input ror_chars_t s, input bit spare);
        apb_write(REG_CANVAS, s.canvas_char);
        apb_write(REG_INTERIOR, s.interior_char);
        apb_write(REG_HORIZONTAL, s.horizontal_char);
        apb_write(REG_VERTICAL, s.vertical_char);
        apb_write(REG_INTERSECTION, s.intersection_char);
        apb_write(REG_CORNER, s.corner_char);
        if (spare)
        begin
            apb_write(REG_SPARE_LO, 8'($urandom()));
            apb_write(REG_SPARE_HI, 8'($urandom()));
        end
        chars = s;
        n_settings++;
        check_regs();
    endtask

    // Result side: every done strobe is a transfer, matched in order.
    always @(posedge clk)
    begin
        ack_t a;
        if (rst_n && done === 1'b1)
        begin
            if (pending_acks.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result op=%0d cell=%02h",
                                          done_op, cell_char));
            end
            else
            begin
                a = pending_acks.pop_front();
                if (done_op !== a.op)
                    report_mismatch($sformatf("done_op %0d, expected %0d", done_op, a.op));
                if (cell_char !== a.char_code)
                    report_mismatch($sformatf("op %0d cell_char %02h, expected %02h",
                                              a.op, cell_char, a.char_code));
            end
        end
    end

    initial
    begin
        cmd_t       dir_tab [$];
        cmd_t       c;
        ror_chars_t s;
        int         ph, k, r, i;

        chars = '{RST_CANVAS_CHAR, RST_INTERIOR_CHAR, RST_HORIZONTAL_CHAR,
                  RST_VERTICAL_CHAR, RST_INTERSECTION_CHAR, RST_CORNER_CHAR};
        for (i = 0; i < CELLS; i++)
            canvas[i] = 8'h00;

        // The canvas is undefined until filled, so the table opens with a fill.
        dir_tab.push_back(mk(OP_FILL, 0, 0, 0, 0, 46, 1, 0));
        dir_tab.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 1, 46));
        dir_tab.push_back(mk(OP_READ, 63, 31, 63, 31, 255, 1, 46));
        // Border around the whole canvas
        dir_tab.push_back(mk(OP_DRAW, 0, 31, 63, 31, 0));
        dir_tab.push_back(mk(OP_READ, 0, 31, 0, 0, 0, 1, 43));
        dir_tab.push_back(mk(OP_READ, 63, 0, 0, 0, 0, 1, 43));
        dir_tab.push_back(mk(OP_READ, 10, 31, 0, 0, 0, 1, 45));
        dir_tab.push_back(mk(OP_READ, 0, 10, 0, 0, 0, 1, 124));
        dir_tab.push_back(mk(OP_READ, 10, 10, 0, 0, 0, 1, 35));
        // Zero width and height: a single corner
        dir_tab.push_back(mk(OP_DRAW, 10, 20, 0, 0, 0));
        dir_tab.push_back(mk(OP_READ, 10, 20, 0, 0, 0, 1, 43));
        // Zero height across that corner: edge meets a drawn mark
        dir_tab.push_back(mk(OP_DRAW, 5, 20, 10, 0, 0));
        dir_tab.push_back(mk(OP_READ, 10, 20, 0, 0, 0));
        dir_tab.push_back(mk(OP_READ, 7, 20, 0, 0, 0));
        // Rectangle running off the right and top of the canvas
        dir_tab.push_back(mk(OP_DRAW, 58, 3, 20, 10, 0));
        dir_tab.push_back(mk(OP_READ, 58, 3, 0, 0, 0, 1, 43));
        dir_tab.push_back(mk(OP_READ, 58, 0, 0, 0, 0));
        // Overlapping rectangles
        dir_tab.push_back(mk(OP_DRAW, 20, 25, 15, 10, 0));
        dir_tab.push_back(mk(OP_DRAW, 25, 28, 15, 10, 0));
        dir_tab.push_back(mk(OP_READ, 25, 25, 0, 0, 0));
        dir_tab.push_back(mk(OP_READ, 35, 20, 0, 0, 0));
        dir_tab.push_back(mk(OP_NOP, 63, 31, 63, 31, 255, 1, 0));
        dir_tab.push_back(mk(OP_FILL, 0, 0, 0, 0, 255, 1, 0));
        dir_tab.push_back(mk(OP_DRAW, 0, 0, 0, 31, 0));
        dir_tab.push_back(mk(OP_READ, 0, 0, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_regs();

        foreach (dir_tab[j])
        begin
            send_cmd(dir_tab[j]);
            pause_after_cmd();
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0: s = ror_chars_t'(48'({$urandom(), $urandom()}));
                1: s = '{default: 8'h00};
                2: s = '{default: 8'hFF};
                3:
                begin
                    // Narrow range so that the characters collide
                    s.canvas_char       = 8'($urandom_range(0, 3));
                    s.interior_char     = 8'($urandom_range(0, 3));
                    s.horizontal_char   = 8'($urandom_range(0, 3));
                    s.vertical_char     = 8'($urandom_range(0, 3));
                    s.intersection_char = 8'($urandom_range(0, 3));
                    s.corner_char       = 8'($urandom_range(0, 3));
                end
                default: s = '{RST_CANVAS_CHAR, RST_INTERIOR_CHAR, RST_HORIZONTAL_CHAR,
                               RST_VERTICAL_CHAR, RST_INTERSECTION_CHAR, RST_CORNER_CHAR};
            endcase
            apply_setting(s, ph == 0 || ph == 3);

            for (k = 0; k < PHASE_CMDS; k++)
            begin
                r = $urandom_range(0, 99);
                c = mk(OP_NOP, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                if (k == 0 || r < 8)
                begin
                    c.op = OP_FILL;
                    if ($urandom_range(0, 9) < 6)
                        c.fc = chars.canvas_char;
                end
                else if (r < 50)
                begin
                    c.op = OP_DRAW;
                    if ($urandom_range(0, 9) < 7)
                    begin
                        c.w = 6'($urandom_range(0, 15));
                        c.h = 5'($urandom_range(0, 10));
                    end
                    last_l = int'(c.x);
                    last_r = last_l + int'(c.w);
                    last_b = int'(c.y);
                    last_t = last_b - int'(c.h);
                end
                else if (r < 95)
                begin
                    c.op = OP_READ;
                    // Aim half the reads at or just inside the outline of the latest rectangle
                    if ($urandom_range(0, 1) == 1)
                    begin
                        case ($urandom_range(0, 3))
                            0: c.x = 6'(last_l);
                            1: c.x = 6'(last_r);
                            2: c.x = 6'(last_l + 1);
                            default: c.x = 6'(last_r - 1);
                        endcase
                        case ($urandom_range(0, 3))
                            0: c.y = 5'(last_b);
                            1: c.y = 5'(last_t);
                            2: c.y = 5'(last_b - 1);
                            default: c.y = 5'(last_t + 1);
                        endcase
                    end
                end
                send_cmd(c);
                pause_after_cmd();
            end
        end

        start <= 1'b0;
        while (pending_acks.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d commands: %0d fills, %0d draws, %0d reads, %0d no-ops",
                 n_fill + n_draw + n_read + n_nop, n_fill, n_draw, n_read, n_nop);
        $display("Ran under %0d character settings, %0d mismatches", n_settings, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/ror_pkg.sv
rtl/ror_cfg_regs.sv
rtl/ror_canvas_ram.sv
rtl/ror_ctrl.sv
rtl/rectangle_outline_rasterizer.sv
rtl/ror_checker.sv
test/tb.sv
